### design/rgb_led_color_register_bank_top_assert.svh
// Assertion macros for the LED color register bank.
`ifndef RGB_LED_COLOR_REGISTER_BANK_TOP_ASSERT_SVH
`define RGB_LED_COLOR_REGISTER_BANK_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RGBLED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbled assertion failed");
`define RGBLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbled assertion failed");
`else
`define RGBLED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RGBLED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/rgbled_pkg.sv
package rgbled_pkg;

    localparam int LED_SLOTS_DEF = 16;
    localparam int CNT_W         = 5;
    localparam int IDX_W         = 4;
    localparam int POS_W         = 3;
    localparam int BANK_LEDS     = 8;

    localparam logic [CNT_W-1:0] LED_COUNT_RST = 5'd16;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ONE    = 2'd1;
    localparam logic [1:0] KIND_BANK   = 2'd2;

    localparam logic [2:0] CHAN_RED   = 3'd0;
    localparam logic [2:0] CHAN_GREEN = 3'd1;
    localparam logic [2:0] CHAN_BLUE  = 3'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [3:0]                 prio;
        logic [IDX_W-1:0]           first;
        logic [IDX_W-1:0]           last;
        logic [2:0]                 chan;
        logic [BANK_LEDS-1:0][7:0]  data;
    } t_cmd;

endpackage

### design/rgbled_front.sv
module rgbled_front #(
    parameter int LED_SLOTS = rgbled_pkg::LED_SLOTS_DEF
) (
    input  logic                        i_start,
    input  logic                        i_full,
    input  logic [rgbled_pkg::CNT_W-1:0] i_led_count,
    input  logic [1:0]                  i_kind,
    input  logic [3:0]                  i_priority_req,
    input  logic [7:0]                  i_target,
    input  logic [3:0]                  i_data_length,
    input  logic [rgbled_pkg::BANK_LEDS-1:0][7:0] i_data,
    output logic                        o_push,
    output rgbled_pkg::t_cmd            o_cmd
);
    import rgbled_pkg::*;

    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(LED_SLOTS);

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] top_full;
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] num;
    logic             idx_ok;
    logic             bank_ok;
    logic             ok;

    always_comb begin
        cnt      = (i_led_count > SLOTS) ? SLOTS : i_led_count;
        idx_ok   = i_target < {3'b000, cnt};
        base     = i_target[0] ? CNT_W'(BANK_LEDS) : '0;
        top_full = base + CNT_W'(BANK_LEDS - 1);
        top      = (top_full >= cnt) ? cnt - 1'b1 : top_full;
        num      = top - base + 1'b1;
        bank_ok  = (base < cnt) && ({1'b0, i_data_length} >= num)
                   && (i_target[3:1] <= CHAN_BLUE);

        o_cmd.kind = i_kind;
        o_cmd.prio = (i_kind == KIND_STATUS) ? i_priority_req : 4'd0;
        o_cmd.chan = i_target[3:1];
        o_cmd.data = i_data;
        ok         = 1'b0;
        unique case (i_kind)
            KIND_STATUS: begin
                ok          = idx_ok;
                o_cmd.first = i_target[IDX_W-1:0];
                o_cmd.last  = i_target[IDX_W-1:0];
            end
            KIND_ONE: begin
                ok          = idx_ok && (i_data_length >= 4'd3);
                o_cmd.first = i_target[IDX_W-1:0];
                o_cmd.last  = i_target[IDX_W-1:0];
            end
            KIND_BANK: begin
                ok          = bank_ok;
                o_cmd.first = base[IDX_W-1:0];
                o_cmd.last  = top[IDX_W-1:0];
            end
            default: begin
                ok          = 1'b0;
                o_cmd.first = '0;
                o_cmd.last  = '0;
            end
        endcase
        o_push = i_start && !i_full && ok;
    end

endmodule

### design/rgbled_queue.sv
module rgbled_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rgbled_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rgbled_pkg::t_cmd o_head
);
    import rgbled_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_head  = r_slot[r_rd];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_cmd;
    end

endmodule

### design/rgbled_back.sv
module rgbled_back #(
    parameter int LED_SLOTS = rgbled_pkg::LED_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  rgbled_pkg::t_cmd i_head,
    output logic             o_pop,
    output logic             o_valid,
    output logic             o_result_kind,
    output logic [3:0]       o_echo_priority,
    output logic [3:0]       o_led_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_last
);
    import rgbled_pkg::*;

    localparam int SW = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;

    t_rgb             r_store [LED_SLOTS];
    logic [POS_W-1:0] r_pos;
    logic [IDX_W-1:0] idx;
    logic [SW-1:0]    sidx;
    logic             is_last;
    logic [7:0]       val;
    t_rgb             old_c;
    t_rgb             new_c;
    logic             wr;

    always_comb begin
        idx     = i_head.first + IDX_W'(r_pos);
        sidx    = idx[SW-1:0];
        is_last = idx == i_head.last;
        val     = i_head.data[r_pos];
        old_c   = r_store[sidx];
        new_c   = old_c;
        wr      = 1'b0;
        case (i_head.kind)
            KIND_ONE: begin
                wr          = 1'b1;
                new_c.red   = i_head.data[0];
                new_c.green = i_head.data[1];
                new_c.blue  = i_head.data[2];
            end
            KIND_BANK: begin
                wr = 1'b1;
                if (i_head.chan == CHAN_RED) begin
                    new_c.red = val;
                end else if (i_head.chan == CHAN_GREEN) begin
                    new_c.green = val;
                end else begin
                    new_c.blue = val;
                end
            end
            default: begin
                wr = 1'b0;
            end
        endcase
        o_pop = !i_empty && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < LED_SLOTS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            o_valid <= !i_empty;
            if (!i_empty) begin
                r_pos <= is_last ? '0 : r_pos + 1'b1;
                if (wr) r_store[sidx] <= new_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_empty) begin
            o_result_kind   <= i_head.kind != KIND_STATUS;
            o_echo_priority <= i_head.prio;
            o_led_index     <= idx;
            o_red           <= new_c.red;
            o_green         <= new_c.green;
            o_blue          <= new_c.blue;
            o_last          <= is_last;
        end
    end

endmodule

### design/rgb_led_color_register_bank_top.sv
// Color store for up to LED_SLOTS RGB LEDs. A command is taken when start is
// high and busy is low; it is checked on entry and parked in a two-word queue,
// and busy is high only while that queue is full. The executing side retires
// one result per clock: a status request or a single-LED write gives one word,
// a bank write gives one word per LED of the clipped bank.
// When the queue is empty, a taken command is written into a queue slot and its
// first word is then registered into the output registers. Each word is on
// the outputs for exactly one cycle while o_valid is high; the words of one
// command come on consecutive cycles and the final one carries o_last. The
// receiver cannot stall the output. Commands that fail their checks produce
// nothing. The color store is cleared by reset; the user must write led_count
// through the cfg channel while idle, which the block itself does not enforce.
`include "rgb_led_color_register_bank_top_assert.svh"

module rgb_led_color_register_bank_top #(
    parameter int LED_SLOTS = rgbled_pkg::LED_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_priority_req,
    input  logic [7:0]  i_target,
    input  logic [3:0]  i_data_length,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    input  logic [7:0]  i_byte4,
    input  logic [7:0]  i_byte5,
    input  logic [7:0]  i_byte6,
    input  logic [7:0]  i_byte7,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [rgbled_pkg::CNT_W-1:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_result_kind,
    output logic [3:0]  o_echo_priority,
    output logic [3:0]  o_led_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last
);
    import rgbled_pkg::*;

    logic [CNT_W-1:0]          r_led_count;
    logic [BANK_LEDS-1:0][7:0] data;
    logic                      push;
    logic                      pop;
    logic                      full;
    logic                      empty;
    t_cmd                      cmd;
    t_cmd                      head;

    assign o_cfg_ready = 1'b1;
    assign busy        = full;
    assign data        = {i_byte7, i_byte6, i_byte5, i_byte4,
                          i_byte3, i_byte2, i_byte1, i_byte0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= LED_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_led_count <= i_cfg_data;
        end
    end

    rgbled_front #(.LED_SLOTS(LED_SLOTS)) u_front (
        .i_start        (start),
        .i_full         (full),
        .i_led_count    (r_led_count),
        .i_kind         (i_kind),
        .i_priority_req (i_priority_req),
        .i_target       (i_target),
        .i_data_length  (i_data_length),
        .i_data         (data),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    rgbled_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    rgbled_back #(.LED_SLOTS(LED_SLOTS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_echo_priority (o_echo_priority),
        .o_led_index     (o_led_index),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_last          (o_last)
    );

    `RGBLED_ASSERT_IMP(a_status_single, i_clk, i_rst_n, o_valid && !o_result_kind, o_last)
    `RGBLED_ASSERT_IMP(a_prio_status, i_clk, i_rst_n, o_valid && o_result_kind, o_echo_priority == 4'd0)
    `RGBLED_ASSERT_NEXT(a_run_no_gap, i_clk, i_rst_n, o_valid && !o_last, o_valid)
    `RGBLED_ASSERT_NEXT(a_run_step, i_clk, i_rst_n, o_valid && !o_last, o_led_index == $past(o_led_index) + 4'd1)

endmodule
